// File: hdl/uniform_range_rejection_sampler_macros.svh
// Assertion helpers for the range sampler; clocked on clk, off while rst_n is low.
`ifndef UNIFORM_RANGE_REJECTION_SAMPLER_MACROS_SVH
`define UNIFORM_RANGE_REJECTION_SAMPLER_MACROS_SVH

// Same-cycle implication.
`define URRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define URRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/urrs_pkg.sv
package urrs_pkg;

  localparam int WORD_W    = 32;
  localparam int CNT_W     = 4;
  localparam int BIT_CNT_W = $clog2(WORD_W);

  localparam logic [CNT_W-1:0]     MAX_RETRIES = CNT_W'(10);
  localparam logic [WORD_W-1:0]    BOUND_MIN   = WORD_W'(2);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT    = BIT_CNT_W'(WORD_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_THRESH = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

// File: hdl/uniform_range_rejection_sampler.sv
// Uniform range sampler: each input word is one attempt of an entropy source
// (in_tuser = source valid flag). A valid word below the rejection threshold
// (2^32 mod bound) is dropped without a result; any other valid word gives
// word mod bound. With the bound below two every valid attempt gives 0.
// Ten invalid attempts in a row give an error word (value 0, failed 1); any
// valid attempt clears that count. An attempt that gives no result keeps in_tready
// high; a modulo result passes through acceptance, 32 shift-subtract steps of
// the one shared remainder unit and the handoff to the output register. Writing
// the bound reruns the same unit for the threshold with in_tready low (not at
// all when the bound is below two). A finished result waits in the output
// register while the next attempt is accepted.
`include "uniform_range_rejection_sampler_macros.svh"

module uniform_range_rejection_sampler (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: range bound
  input  logic                        cfg_wr_en,
  input  logic [urrs_pkg::WORD_W-1:0] cfg_wr_data,
  // input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [urrs_pkg::WORD_W-1:0] in_tdata,   // [31:0] random_word
  input  logic                        in_tuser,   // [0] word_valid
  // result words
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [urrs_pkg::WORD_W-1:0] out_tdata,  // [31:0] value
  output logic                        out_tuser   // [0] failed
);
  import urrs_pkg::*;

  state_t                 state_r, state_nxt;
  logic [WORD_W-1:0]      bound_r, bound_nxt;
  logic [WORD_W-1:0]      thresh_r, thresh_nxt;
  logic [CNT_W-1:0]       fail_cnt_r, fail_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // shared remainder unit state
  logic [WORD_W-1:0]      rem_r, rem_nxt;
  logic [WORD_W-1:0]      dvd_r, dvd_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;

  // pending result and output register
  logic [WORD_W-1:0]      res_value_r, res_value_nxt;
  logic                   res_failed_r, res_failed_nxt;
  logic [WORD_W-1:0]      out_value_r, out_value_nxt;
  logic                   out_failed_r, out_failed_nxt;

  logic [WORD_W:0]        part_w;
  logic [WORD_W+1:0]      diff_w;
  logic [WORD_W-1:0]      rem_step;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   out_load;

  // one restoring step: shift in next dividend bit, subtract bound if it fits
  always_comb begin
    part_w   = {rem_r, dvd_r[WORD_W-1]};
    diff_w   = {1'b0, part_w} - {2'b00, bound_r};
    rem_step = diff_w[WORD_W+1] ? part_w[WORD_W-1:0] : diff_w[WORD_W-1:0];
  end

  assign cnt_inc   = fail_cnt_r + CNT_W'(1);
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    bound_nxt      = bound_r;
    thresh_nxt     = thresh_r;
    fail_cnt_nxt   = fail_cnt_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    bit_cnt_nxt    = bit_cnt_r;
    res_value_nxt  = res_value_r;
    res_failed_nxt = res_failed_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) begin
            if (cnt_inc >= MAX_RETRIES) begin
              fail_cnt_nxt   = '0;
              res_value_nxt  = '0;
              res_failed_nxt = 1'b1;
              state_nxt      = ST_FINISH;
            end else begin
              fail_cnt_nxt = cnt_inc;
            end
          end else begin
            fail_cnt_nxt = '0;
            if (bound_r < BOUND_MIN) begin
              res_value_nxt  = '0;
              res_failed_nxt = 1'b0;
              state_nxt      = ST_FINISH;
            end else if (in_tdata >= thresh_r) begin
              rem_nxt     = '0;
              dvd_nxt     = in_tdata;
              bit_cnt_nxt = '0;
              state_nxt   = ST_DIV;
            end
          end
        end
      end
      ST_THRESH, ST_DIV: begin
        rem_nxt     = rem_step;
        dvd_nxt     = {dvd_r[WORD_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == LAST_BIT) begin
          if (state_r == ST_THRESH) begin
            thresh_nxt = rem_step;
            state_nxt  = ST_IDLE;
          end else begin
            res_value_nxt  = rem_step;
            res_failed_nxt = 1'b0;
            state_nxt      = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // new bound: threshold = (2^32 - bound) mod bound
    if (cfg_wr_en) begin
      bound_nxt = cfg_wr_data;
      if (cfg_wr_data < BOUND_MIN) begin
        thresh_nxt = '0;
        state_nxt  = ST_IDLE;
      end else begin
        rem_nxt     = '0;
        dvd_nxt     = '0 - cfg_wr_data;
        bit_cnt_nxt = '0;
        state_nxt   = ST_THRESH;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_failed_nxt = out_failed_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = res_value_r;
      out_failed_nxt = res_failed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bound_r     <= '0;
      thresh_r    <= '0;
      fail_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bound_r     <= bound_nxt;
      thresh_r    <= thresh_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    res_value_r  <= res_value_nxt;
    res_failed_r <= res_failed_nxt;
    out_value_r  <= out_value_nxt;
    out_failed_r <= out_failed_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_failed_r;

  `URRS_ASSERT_NOW(a_fail_cnt_range, 1'b1, fail_cnt_r < MAX_RETRIES, "fail count at limit")
  `URRS_ASSERT_NOW(a_rem_below_bound, (state_r == ST_DIV) || (state_r == ST_THRESH),
                   rem_r < bound_r, "partial remainder not reduced")
  `URRS_ASSERT_NOW(a_thresh_below_bound, (state_r == ST_IDLE) && (bound_r >= BOUND_MIN),
                   thresh_r < bound_r, "threshold out of range")
  `URRS_ASSERT_NOW(a_error_clears_cnt, (state_r == ST_FINISH) && res_failed_r,
                   (fail_cnt_r == '0) && (res_value_r == '0), "error result state wrong")

endmodule
